### src/tbpc_pkg.sv
// Package with shared types, widths and reset values of the three-button player control.
package tbpc_pkg;

	localparam int TRACK_SLOTS = 32;
	localparam int TRACK_LIM   = (TRACK_SLOTS < 32) ? TRACK_SLOTS : 32;

	localparam int TIME_W   = 32;
	localparam int MS_W     = 16;
	localparam int CNT_W    = 6;
	localparam int TRACK_W  = 5;
	localparam int VOL_W    = 5;
	localparam int CFG_IX_W = 3;
	localparam int CFG_D_W  = 16;
	localparam int IN_W     = 40;
	localparam int OUT_W    = 24;

	localparam logic [MS_W-1:0]    LONG_PRESS_RST = MS_W'(700);
	localparam logic [MS_W-1:0]    VLONG_PRESS_RST = MS_W'(3000);
	localparam logic [MS_W-1:0]    LOCKOUT_RST = MS_W'(250);
	localparam logic [MS_W-1:0]    VOL_REPEAT_RST = MS_W'(120);
	localparam logic [CNT_W-1:0]   TRACK_COUNT_RST = CNT_W'(1);
	localparam logic [TRACK_W-1:0] START_TRACK_RST = TRACK_W'(0);
	localparam logic [VOL_W-1:0]   START_VOL_RST = VOL_W'(14);
	localparam logic [VOL_W-1:0]   MAX_VOL_RST = VOL_W'(21);
	localparam logic [CNT_W-1:0]   TRACK_LIM_C = CNT_W'(TRACK_LIM);

	typedef enum logic [CFG_IX_W-1:0] {
		CFG_LONG_PRESS  = 3'd0,
		CFG_VLONG_PRESS = 3'd1,
		CFG_LOCKOUT     = 3'd2,
		CFG_VOL_REPEAT  = 3'd3,
		CFG_TRACK_COUNT = 3'd4,
		CFG_START_TRACK = 3'd5,
		CFG_START_VOL   = 3'd6,
		CFG_MAX_VOL     = 3'd7
	} cfg_idx_t;

	// Input request, last field in the lowest bits.
	typedef struct packed {
		logic              prev_level;
		logic              next_level;
		logic              play_level;
		logic [TIME_W-1:0] now_ms;
	} in_item_t;

	// Result request, last field in the lowest bits.
	typedef struct packed {
		logic               volume_changed;
		logic               enter_sleep;
		logic               toggle_pause;
		logic               restart_track;
		logic               volume_display;
		logic               asleep;
		logic               paused;
		logic [VOL_W-1:0]   volume_level;
		logic [TRACK_W-1:0] track_index;
	} out_item_t;

endpackage

### src/three_button_player_control_core.sv
// Top level of the three-button player control: button decoding, volume and track state.
//
//  Channel  Direction  Handshake                 Payload
//  s_*      in         s_tvalid / s_tready       s_tdata: now_ms, play, next, prev levels
//  m_*      out        m_tvalid / m_tready       m_tdata: state and event pulses
//  cfg_*    in         cfg_we (no wait)          cfg_index, cfg_data
//
// One request is taken per clock cycle when the output side keeps up. A request
// is held in the input register, is evaluated by a single pass of compare
// and update logic and lands in the result register. A stalled result holds
// the input register; the input side is ready again as soon as that result is
// taken. Reset clears all state to the documented values at once; there is no
// clearing pass.
module three_button_player_control_core
	import tbpc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [IN_W-1:0]     s_tdata,   // now_ms[31:0], play_level, next_level, prev_level
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OUT_W-1:0]    m_tdata,   // track_index[4:0], volume_level[4:0], paused,
	                                       // asleep, volume_display, restart_track,
	                                       // toggle_pause, enter_sleep, volume_changed
	input  logic                cfg_we,
	input  logic [CFG_IX_W-1:0] cfg_index,
	input  logic [CFG_D_W-1:0]  cfg_data
);

	// Configuration registers.
	logic [MS_W-1:0]    long_q, vlong_q, lockout_q, repeat_q;
	logic [CNT_W-1:0]   tcount_q;
	logic [VOL_W-1:0]   max_vol_q;

	// Input stage.
	logic     in_valid_s1;
	in_item_t in_s1;

	// Output register.
	logic      out_valid_q;
	out_item_t out_q;

	// Player state.
	logic               play_lvl_q, next_lvl_q, prev_lvl_q;
	logic [TIME_W-1:0]  play_stamp_q, next_stamp_q, prev_stamp_q;
	logic [TIME_W-1:0]  action_stamp_q, vol_stamp_q;
	logic [TRACK_W-1:0] track_q;
	logic [VOL_W-1:0]   volume_q;
	logic               paused_q, asleep_q, vdisp_q;

	logic advance;

	assign advance  = in_valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !in_valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_W - $bits(out_item_t)){1'b0}}, out_q};

	// The wrap count is the track count register saturated to the usable range.
	logic [CNT_W-1:0] cnt;
	always_comb begin
		if (tcount_q == '0) begin
			cnt = CNT_W'(1);
		end else if (tcount_q > TRACK_LIM_C) begin
			cnt = TRACK_LIM_C;
		end else begin
			cnt = tcount_q;
		end
	end

	// Step evaluation. The three sections of one request act in the order play,
	// next, prev. Once one release acts it stamps the lockout with the current
	// time, which blocks later releases in the same request; the same holds for
	// volume steps and their repeat stamp. That lets every compare use the
	// stored stamps directly.
	logic [TIME_W-1:0]  now, play_held, next_held, prev_held;
	logic               p, n, r;
	logic               play_fall, next_rise, next_fall, prev_rise, prev_fall, play_rise;
	logic               lock_ok, vol_ok;
	logic               play_act, do_sleep, do_restart_p, do_toggle;
	logic               next_step, next_act, next_short;
	logic               prev_step, prev_act, prev_short;
	logic               next_move, prev_move;
	logic [CNT_W-1:0]   t_inc, t_mid;
	logic [TRACK_W-1:0] track_d;
	logic [VOL_W:0]     v_inc;
	logic [VOL_W-1:0]   volume_d;
	logic               paused_d, vdisp_d;
	out_item_t          res;

	always_comb begin
		now = in_s1.now_ms;
		p   = in_s1.play_level;
		n   = in_s1.next_level;
		r   = in_s1.prev_level;

		play_rise = p && !play_lvl_q;
		play_fall = !p && play_lvl_q;
		next_rise = n && !next_lvl_q;
		next_fall = !n && next_lvl_q;
		prev_rise = r && !prev_lvl_q;
		prev_fall = !r && prev_lvl_q;

		lock_ok = (now - action_stamp_q) > {{(TIME_W-MS_W){1'b0}}, lockout_q};
		vol_ok  = (now - vol_stamp_q) > {{(TIME_W-MS_W){1'b0}}, repeat_q};

		// A rising edge of next or prev restamps, so its hold time then reads as zero.
		play_held = now - play_stamp_q;
		next_held = next_rise ? '0 : now - next_stamp_q;
		prev_held = prev_rise ? '0 : now - prev_stamp_q;

		play_act     = play_fall && lock_ok;
		do_sleep     = play_act && paused_q &&
		               (play_held > {{(TIME_W-MS_W){1'b0}}, vlong_q});
		do_restart_p = play_act && !do_sleep &&
		               (play_held > {{(TIME_W-MS_W){1'b0}}, long_q});
		do_toggle    = play_act && !do_sleep && !do_restart_p;

		next_step  = n && vol_ok && (next_held > {{(TIME_W-MS_W){1'b0}}, long_q});
		next_act   = next_fall && lock_ok && !play_act;
		next_short = next_held <= {{(TIME_W-MS_W){1'b0}}, long_q};
		next_move  = next_act && next_short;

		prev_step  = r && vol_ok && !next_step &&
		             (prev_held > {{(TIME_W-MS_W){1'b0}}, long_q});
		prev_act   = prev_fall && lock_ok && !play_act && !next_act;
		prev_short = prev_held <= {{(TIME_W-MS_W){1'b0}}, long_q};
		prev_move  = prev_act && prev_short;

		// Track index: next wraps to zero, prev wraps to the last track.
		t_inc = {1'b0, track_q} + CNT_W'(1);
		t_mid = {1'b0, track_q};
		if (next_move) begin
			t_mid = (t_inc >= cnt) ? '0 : t_inc;
		end
		if (prev_move) begin
			if (t_mid == '0 || t_mid >= cnt) begin
				t_mid = cnt - CNT_W'(1);
			end else begin
				t_mid = t_mid - CNT_W'(1);
			end
		end
		track_d = t_mid[TRACK_W-1:0];

		// Volume: at most one step per request.
		v_inc    = {1'b0, volume_q} + (VOL_W+1)'(1);
		volume_d = volume_q;
		if (next_step) begin
			volume_d = (volume_q != '0) ? volume_q - VOL_W'(1) : volume_q;
		end else if (prev_step) begin
			volume_d = (v_inc > {1'b0, max_vol_q}) ? max_vol_q : v_inc[VOL_W-1:0];
		end

		paused_d = paused_q;
		if (do_restart_p) begin
			paused_d = 1'b0;
		end else if (do_toggle) begin
			paused_d = !paused_q;
		end
		if (next_move || prev_move) begin
			paused_d = 1'b0;
		end

		vdisp_d = vdisp_q;
		if (next_step) begin
			vdisp_d = 1'b1;
		end
		if (next_act) begin
			vdisp_d = 1'b0;
		end
		if (prev_step) begin
			vdisp_d = 1'b1;
		end
		if (prev_act) begin
			vdisp_d = 1'b0;
		end

		res.track_index    = track_d;
		res.volume_level   = volume_d;
		res.paused         = paused_d;
		res.asleep         = asleep_q || do_sleep;
		res.volume_display = vdisp_d;
		res.restart_track  = do_restart_p || next_move || prev_move;
		res.toggle_pause   = do_toggle;
		res.enter_sleep    = do_sleep;
		res.volume_changed = next_step || prev_step;
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			in_s1 <= in_item_t'(s_tdata[$bits(in_item_t)-1:0]);
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	// Player state and configuration. The user must write configuration only while
	// no request is in flight, so preload writes never meet a step update; the
	// block does not enforce this. The start track and start volume only act
	// through the preload, so they need no register of their own.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_q         <= LONG_PRESS_RST;
			vlong_q        <= VLONG_PRESS_RST;
			lockout_q      <= LOCKOUT_RST;
			repeat_q       <= VOL_REPEAT_RST;
			tcount_q       <= TRACK_COUNT_RST;
			max_vol_q      <= MAX_VOL_RST;
			play_lvl_q     <= 1'b0;
			next_lvl_q     <= 1'b0;
			prev_lvl_q     <= 1'b0;
			play_stamp_q   <= '0;
			next_stamp_q   <= '0;
			prev_stamp_q   <= '0;
			action_stamp_q <= '0;
			vol_stamp_q    <= '0;
			track_q        <= START_TRACK_RST;
			volume_q       <= START_VOL_RST;
			paused_q       <= 1'b1;
			asleep_q       <= 1'b0;
			vdisp_q        <= 1'b0;
		end else begin
			if (advance) begin
				play_lvl_q <= p;
				next_lvl_q <= n;
				prev_lvl_q <= r;
				if (play_rise) begin
					play_stamp_q <= now;
				end
				if (next_rise) begin
					next_stamp_q <= now;
				end
				if (prev_rise) begin
					prev_stamp_q <= now;
				end
				if (play_act || next_act || prev_act) begin
					action_stamp_q <= now;
				end
				if (next_step || prev_step) begin
					vol_stamp_q <= now;
				end
				track_q  <= track_d;
				volume_q <= volume_d;
				paused_q <= paused_d;
				asleep_q <= res.asleep;
				vdisp_q  <= vdisp_d;
			end
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_LONG_PRESS:  long_q    <= cfg_data;
					CFG_VLONG_PRESS: vlong_q   <= cfg_data;
					CFG_LOCKOUT:     lockout_q <= cfg_data;
					CFG_VOL_REPEAT:  repeat_q  <= cfg_data;
					CFG_TRACK_COUNT: tcount_q  <= cfg_data[CNT_W-1:0];
					CFG_START_TRACK: begin
						track_q <= ({1'b0, cfg_data[TRACK_W-1:0]} < cnt) ?
						           cfg_data[TRACK_W-1:0] : '0;
					end
					CFG_START_VOL: begin
						volume_q <= (cfg_data[VOL_W-1:0] > max_vol_q) ?
						            max_vol_q : cfg_data[VOL_W-1:0];
					end
					CFG_MAX_VOL:     max_vol_q <= cfg_data[VOL_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

endmodule

### src/tbpc_checker.sv
// Port-level checker for the three-button player control, bound to the top level.
module tbpc_checker
	import tbpc_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [OUT_W-1:0]    m_tdata
);

	out_item_t res;
	assign res = out_item_t'(m_tdata[$bits(out_item_t)-1:0]);

	// A stalled result keeps its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// At most one of the playback event pulses in a single result.
	a_pulses: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $onehot0({res.restart_track, res.toggle_pause, res.enter_sleep}))
		else $error("more than one playback event in one result");

	// Entering sleep always shows the sticky sleep flag.
	a_sleep: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.enter_sleep |-> res.asleep)
		else $error("sleep entered without sleep flag");

	// A restart always leaves the player running.
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.restart_track |-> !res.paused)
		else $error("restart left the player paused");

endmodule

bind three_button_player_control_core tbpc_checker u_tbpc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata)
);
